// ===== design/wctm_pkg.sv =====
// Package: shared types, codes and sizes for the wall column texture mapper.
`timescale 1ns / 1ps

package wctm_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int ADDR_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 32;
  localparam int SHIFT_W = 5;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Sizes
  localparam int TEX_ADDR_BITS_DEF = 16;
  localparam int SHADE_DEPTH       = 256;
  localparam int BLEND_DEPTH       = 65536;
  localparam int QUEUE_DEPTH       = 4;   // power of two
  localparam int BACK_STAGES       = 3;
  localparam int MAX_INFLIGHT      = QUEUE_DEPTH + BACK_STAGES;

  // Reset values and special texel
  localparam logic [SHIFT_W-1:0] TEXEL_SHIFT_RST = SHIFT_W'(16);
  localparam logic [BYTE_W-1:0]  SKIP_TEXEL      = 8'hFF;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_TEX_WR   = 3'd0;
  localparam logic [OP_W-1:0] OP_SHADE_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_BLEND_WR = 3'd2;
  localparam logic [OP_W-1:0] OP_BEGIN    = 3'd3;
  localparam logic [OP_W-1:0] OP_DRAW     = 3'd4;

  // Draw modes
  localparam logic [MODE_W-1:0] MODE_OPAQUE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MASKED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLEND  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd2;

  // Work kinds passed from front to back
  typedef enum logic [1:0] {
    KIND_TEX_WR,
    KIND_SHADE_WR,
    KIND_BLEND_WR,
    KIND_DRAW
  } kind_t;

  // One queued transaction (texture address travels beside it)
  typedef struct packed {
    kind_t              kind;
    logic [ADDR_W-1:0]  address;
    logic [BYTE_W-1:0]  data;
    logic [BYTE_W-1:0]  dest_pixel;
    logic               end_of_column;
  } q_entry_t;

endpackage

// ===== design/wctm_in_if.sv =====
// Interface: input channel carrying load, begin-column and draw transactions.
`timescale 1ns / 1ps

interface wctm_in_if import wctm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] address;
  logic [BYTE_W-1:0] data;
  logic [POS_W-1:0]  start_position;
  logic [POS_W-1:0]  step;
  logic [BYTE_W-1:0] dest_pixel;
  logic              end_of_column;

  modport source (
    output valid, op, address, data, start_position, step, dest_pixel, end_of_column,
    input  ready
  );
  modport sink (
    input  valid, op, address, data, start_position, step, dest_pixel, end_of_column,
    output ready
  );
endinterface

// ===== design/wctm_out_if.sv =====
// Interface: result channel carrying one pixel per draw transaction.
`timescale 1ns / 1ps

interface wctm_out_if import wctm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] new_pixel;
  logic              write_enable;
  logic              column_done;

  modport source (
    output valid, new_pixel, write_enable, column_done,
    input  ready
  );
  modport sink (
    input  valid, new_pixel, write_enable, column_done,
    output ready
  );
endinterface

// ===== design/wctm_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module wctm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read old contents; hold read data while disabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/wctm_front.sv =====
// Front end: accepts transactions, steps the texture position, queues work.
`timescale 1ns / 1ps

module wctm_front import wctm_pkg::*; #(
  parameter int TEX_ADDR_BITS = TEX_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  wctm_in_if.sink                  in_s,
  input  logic [SHIFT_W-1:0]       texel_shift,
  input  logic                     q_full,
  output logic                     q_push,
  output q_entry_t                 q_entry,
  output logic [TEX_ADDR_BITS-1:0] q_tex_addr
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] step_r, step_nxt;
  logic [POS_W-1:0] shifted;
  logic [POS_W-1:0] addr_ext;
  logic             acc;
  kind_t            kind;

  assign in_s.ready = !q_full;
  assign acc        = in_s.valid && in_s.ready;
  assign shifted    = pos_r >> texel_shift;
  assign addr_ext   = POS_W'(in_s.address);

  // Classify the transaction; load position on begin and advance it on each draw
  always_comb begin
    pos_nxt    = pos_r;
    step_nxt   = step_r;
    q_push     = 1'b0;
    kind       = KIND_DRAW;
    q_tex_addr = shifted[TEX_ADDR_BITS-1:0];
    case (in_s.op)
      OP_TEX_WR: begin
        q_push     = acc;
        kind       = KIND_TEX_WR;
        q_tex_addr = addr_ext[TEX_ADDR_BITS-1:0];
      end
      OP_SHADE_WR: begin
        q_push = acc;
        kind   = KIND_SHADE_WR;
      end
      OP_BLEND_WR: begin
        q_push = acc;
        kind   = KIND_BLEND_WR;
      end
      OP_BEGIN: begin
        if (acc) begin
          pos_nxt  = in_s.start_position;
          step_nxt = in_s.step;
        end
      end
      OP_DRAW: begin
        q_push = acc;
        kind   = KIND_DRAW;
        if (acc) begin
          pos_nxt = pos_r + step_r;
        end
      end
      default: begin
        // drop unused op codes
      end
    endcase
  end

  always_comb begin
    q_entry.kind          = kind;
    q_entry.address       = in_s.address;
    q_entry.data          = in_s.data;
    q_entry.dest_pixel    = in_s.dest_pixel;
    q_entry.end_of_column = in_s.end_of_column;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      step_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/wctm_queue.sv =====
// Small flop-based FIFO decoupling the front end from the lookup pipeline.
`timescale 1ns / 1ps

module wctm_queue import wctm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Store entry at the write pointer
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/wctm_back.sv =====
// Back end: texture, shade and blend lookups in three stages, one per memory.
`timescale 1ns / 1ps

module wctm_back import wctm_pkg::*; #(
  parameter int TEX_ADDR_BITS = TEX_ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  q_entry_t                 q_head,
  input  logic [TEX_ADDR_BITS-1:0] q_head_tex_addr,
  output logic                     q_pop,
  input  logic [MODE_W-1:0]        draw_mode,
  input  logic                     reverse_order,
  wctm_out_if.source               out_m
);

  logic              adv;
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  q_entry_t          s1_item_r, s2_item_r, s3_item_r;
  logic [BYTE_W-1:0] s2_texel_r, s3_texel_r, s3_shaded_r;

  logic [BYTE_W-1:0] tex_rdata, shade_rdata, blend_rdata;
  logic              shade_en, shade_we, blend_en, blend_we, tex_en, tex_we;
  logic [7:0]        shade_addr;
  logic [ADDR_W-1:0] blend_addr;

  // Whole pipeline moves unless a finished pixel waits at the output
  assign out_m.valid = s3_vld_r && (s3_item_r.kind == KIND_DRAW);
  assign adv         = !out_m.valid || out_m.ready;
  assign q_pop       = adv && !q_empty;

  // Stage 1 access: texture memory (writes kept here to preserve order)
  assign tex_en = q_pop;
  assign tex_we = (q_head.kind == KIND_TEX_WR);

  wctm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << TEX_ADDR_BITS)
  ) u_tex_ram (
    .clk   (clk),
    .en    (tex_en),
    .we    (tex_we),
    .addr  (q_head_tex_addr),
    .wdata (q_head.data),
    .rdata (tex_rdata)
  );

  // Stage 2 access: shade palette indexed by texel
  assign shade_en   = adv && s1_vld_r;
  assign shade_we   = (s1_item_r.kind == KIND_SHADE_WR);
  assign shade_addr = shade_we ? s1_item_r.address[7:0] : tex_rdata;

  wctm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SHADE_DEPTH)
  ) u_shade_ram (
    .clk   (clk),
    .en    (shade_en),
    .we    (shade_we),
    .addr  (shade_addr),
    .wdata (s1_item_r.data),
    .rdata (shade_rdata)
  );

  // Stage 3 access: blend table indexed by shaded and destination bytes
  assign blend_en = adv && s2_vld_r;
  assign blend_we = (s2_item_r.kind == KIND_BLEND_WR);

  always_comb begin
    if (blend_we) begin
      blend_addr = s2_item_r.address;
    end else if (reverse_order) begin
      blend_addr = {shade_rdata, s2_item_r.dest_pixel};
    end else begin
      blend_addr = {s2_item_r.dest_pixel, shade_rdata};
    end
  end

  wctm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BLEND_DEPTH)
  ) u_blend_ram (
    .clk   (clk),
    .en    (blend_en),
    .we    (blend_we),
    .addr  (blend_addr),
    .wdata (s2_item_r.data),
    .rdata (blend_rdata)
  );

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= q_pop;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r   <= q_head;
      s2_item_r   <= s1_item_r;
      s2_texel_r  <= tex_rdata;
      s3_item_r   <= s2_item_r;
      s3_texel_r  <= s2_texel_r;
      s3_shaded_r <= shade_rdata;
    end
  end

  // Pick the pixel by draw mode; masked and blend skip the reserved texel
  always_comb begin
    out_m.column_done = s3_item_r.end_of_column;
    case (draw_mode)
      MODE_OPAQUE: begin
        out_m.new_pixel    = s3_shaded_r;
        out_m.write_enable = 1'b1;
      end
      MODE_MASKED: begin
        if (s3_texel_r == SKIP_TEXEL) begin
          out_m.new_pixel    = s3_item_r.dest_pixel;
          out_m.write_enable = 1'b0;
        end else begin
          out_m.new_pixel    = s3_shaded_r;
          out_m.write_enable = 1'b1;
        end
      end
      default: begin
        // blend mode, and the unused fourth code behaves the same
        if (s3_texel_r == SKIP_TEXEL) begin
          out_m.new_pixel    = s3_item_r.dest_pixel;
          out_m.write_enable = 1'b0;
        end else begin
          out_m.new_pixel    = blend_rdata;
          out_m.write_enable = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== design/wall_column_texture_mapper.sv =====
// Top level: wall column texture mapper with config registers, front, queue, back.
//
//   Channel  Dir  Handshake          Payload
//   in_s     in   valid/ready        op, address, data, start_position, step,
//                                    dest_pixel, end_of_column
//   out_m    out  valid/ready        new_pixel, write_enable, column_done
//   cfg_*    in   cfg_we (no stall)  cfg_index, cfg_wdata
//
// One transaction per cycle sustained while the queue has room; the only loop is the 32-bit position add.
// A draw result passes through the queue, then one stage per memory (texture, shade
// palette, blend table), before it shows on out_m.
// Reset is synchronous; memories are not cleared and need loading before use.
// A stalled result freezes the lookup pipeline; the four-entry queue keeps
// taking transactions until it fills.
`timescale 1ns / 1ps

module wall_column_texture_mapper import wctm_pkg::*; #(
  parameter int TEX_ADDR_BITS = TEX_ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wctm_in_if.sink               in_s,
  wctm_out_if.source            out_m,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QW = $bits(q_entry_t) + TEX_ADDR_BITS;

  logic [SHIFT_W-1:0]       texel_shift_r;
  logic [MODE_W-1:0]        draw_mode_r;
  logic                     reverse_order_r;

  logic                     q_push, q_pop, q_empty, q_full;
  q_entry_t                 f_entry, b_entry;
  logic [TEX_ADDR_BITS-1:0] f_tex_addr, b_tex_addr;
  logic [QW-1:0]            q_push_data, q_pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      texel_shift_r   <= TEXEL_SHIFT_RST;
      draw_mode_r     <= MODE_OPAQUE;
      reverse_order_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEXEL_SHIFT: texel_shift_r   <= cfg_wdata[SHIFT_W-1:0];
        CFG_DRAW_MODE:   draw_mode_r     <= cfg_wdata[MODE_W-1:0];
        CFG_REVERSE:     reverse_order_r <= cfg_wdata[0];
        default: begin
          // ignore writes beyond the register list
        end
      endcase
    end
  end

  wctm_front #(
    .TEX_ADDR_BITS (TEX_ADDR_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_s),
    .texel_shift (texel_shift_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (f_entry),
    .q_tex_addr  (f_tex_addr)
  );

  // Pack and unpack queue entries
  assign q_push_data = {f_tex_addr, f_entry};
  assign b_entry     = q_entry_t'(q_pop_data[$bits(q_entry_t)-1:0]);
  assign b_tex_addr  = q_pop_data[QW-1 -: TEX_ADDR_BITS];

  wctm_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  wctm_back #(
    .TEX_ADDR_BITS (TEX_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (b_entry),
    .q_head_tex_addr (b_tex_addr),
    .q_pop           (q_pop),
    .draw_mode       (draw_mode_r),
    .reverse_order   (reverse_order_r),
    .out_m           (out_m)
  );

endmodule

// ===== design/wctm_checker.sv =====
// Checker on the top-level ports of the texture mapper, bound to the top level.
`timescale 1ns / 1ps

module wctm_checker import wctm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [OP_W-1:0]       in_op,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [BYTE_W-1:0]     out_new_pixel,
  input logic                  out_write_enable,
  input logic                  out_column_done,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [3:0]        pending_r, pending_nxt;
  logic [MODE_W-1:0] mode_r;
  logic              draw_in, pix_out;

  assign draw_in = in_valid && in_ready && (in_op == OP_DRAW);
  assign pix_out = out_valid && out_ready;

  // Count draws accepted but not yet delivered
  always_comb begin
    case ({draw_in, pix_out})
      2'b10:   pending_nxt = pending_r + 1'b1;
      2'b01:   pending_nxt = pending_r - 1'b1;
      default: pending_nxt = pending_r;
    endcase
  end

  // Track draw mode and pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      mode_r    <= MODE_OPAQUE;
    end else begin
      pending_r <= pending_nxt;
      if (cfg_we && (cfg_index == CFG_DRAW_MODE)) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_pixel) &&
      $stable(out_write_enable) && $stable(out_column_done))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 4'd0)
    else $error("result without a pending draw");

  a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 4'(MAX_INFLIGHT))
    else $error("more draws in flight than queue and pipeline hold");

  a_opaque_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == MODE_OPAQUE) |-> out_write_enable)
    else $error("opaque mode skipped a pixel");

endmodule

bind wall_column_texture_mapper wctm_checker u_wctm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .in_op            (in_s.op),
  .out_valid        (out_m.valid),
  .out_ready        (out_m.ready),
  .out_new_pixel    (out_m.new_pixel),
  .out_write_enable (out_m.write_enable),
  .out_column_done  (out_m.column_done),
  .cfg_we           (cfg_we),
  .cfg_index        (cfg_index),
  .cfg_wdata        (cfg_wdata)
);

// ===== sim/wall_column_texture_mapper_tb.sv =====
// Testbench for the wall column texture mapper: planned loads, columns and draws checked per pixel.
`timescale 1ns / 1ps

module wall_column_texture_mapper_tb;
  import wctm_pkg::*;

  localparam int TEX_BITS         = TEX_ADDR_BITS_DEF;
  localparam int TEX_DEPTH        = 1 << TEX_BITS;
  localparam int SETTLE_CYCLES    = MAX_INFLIGHT + 4;
  localparam int PHASE_ITEMS      = 100;
  localparam int LONG_HOLD_AFTER  = 60;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam longint TIMEOUT_NS   = 2_000_000;

  // Mode code with no package name; the block decodes it like translucent
  localparam logic [MODE_W-1:0] MODE_BLEND_ALT = 2'd3;
  // Op codes that the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  start_position;
    logic [POS_W-1:0]  step;
    logic [BYTE_W-1:0] dest_pixel;
    logic              end_of_column;
  } span_txn_t;

  typedef struct packed {
    logic [BYTE_W-1:0] new_pixel;
    logic              write_enable;
    logic              column_done;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  idle_on;

  wctm_in_if  column_in ();
  wctm_out_if pixel_out ();

  wall_column_texture_mapper #(
    .TEX_ADDR_BITS(TEX_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (column_in),
    .out_m    (pixel_out),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register mirror, shared by planner and predictor (only changes while idle)
  logic [SHIFT_W-1:0] texel_shift_q;
  logic [MODE_W-1:0]  draw_mode_q;
  logic               reverse_q;

  // Predictor state, advanced on accepted transactions
  logic [BYTE_W-1:0] tex_mem   [TEX_DEPTH];
  logic [BYTE_W-1:0] shade_mem [SHADE_DEPTH];
  logic [BYTE_W-1:0] blend_mem [BLEND_DEPTH];
  logic [POS_W-1:0]  tex_pos;
  logic [POS_W-1:0]  tex_step;
  pixel_t            predicted_pixels[$];

  // Planner shadow: what will have been written when each item is sent
  logic [BYTE_W-1:0] plan_tex       [TEX_DEPTH];
  bit                plan_tex_set   [TEX_DEPTH];
  logic [BYTE_W-1:0] plan_shade     [SHADE_DEPTH];
  bit                plan_shade_set [SHADE_DEPTH];
  bit                plan_blend_set [BLEND_DEPTH];
  logic [POS_W-1:0]  plan_pos;
  logic [POS_W-1:0]  plan_step;
  span_txn_t         column_feed[$];
  int unsigned       feed_count;

  int unsigned mismatch_count;
  int unsigned pixels_checked;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Apply one accepted transaction to the predictor; draws queue a pixel
  task automatic map_transaction(input span_txn_t t);
    logic [BYTE_W-1:0] texel;
    logic [BYTE_W-1:0] shaded;
    pixel_t            px;
    case (t.op)
      OP_TEX_WR:   tex_mem[TEX_BITS'(t.address)] = t.data;
      OP_SHADE_WR: shade_mem[t.address[BYTE_W-1:0]] = t.data;
      OP_BLEND_WR: blend_mem[t.address] = t.data;
      OP_BEGIN: begin
        tex_pos  = t.start_position;
        tex_step = t.step;
      end
      OP_DRAW: begin
        texel   = tex_mem[TEX_BITS'(tex_pos >> texel_shift_q)];
        shaded  = shade_mem[texel];
        tex_pos = tex_pos + tex_step;
        px.new_pixel    = shaded;
        px.write_enable = 1'b1;
        px.column_done  = t.end_of_column;
        if (draw_mode_q != MODE_OPAQUE && texel == SKIP_TEXEL) begin
          px.new_pixel    = t.dest_pixel;
          px.write_enable = 1'b0;
        end else if (draw_mode_q != MODE_OPAQUE && draw_mode_q != MODE_MASKED) begin
          px.new_pixel = reverse_q ? blend_mem[{shaded, t.dest_pixel}]
                                   : blend_mem[{t.dest_pixel, shaded}];
        end
        predicted_pixels.push_back(px);
      end
      default: ;
    endcase
  endtask

  function automatic span_txn_t random_txn(input logic [OP_W-1:0] op);
    span_txn_t t;
    t.op             = op;
    t.address        = ADDR_W'($urandom);
    t.data           = BYTE_W'($urandom);
    t.start_position = $urandom;
    t.step           = $urandom;
    t.dest_pixel     = BYTE_W'($urandom);
    t.end_of_column  = 1'($urandom);
    return t;
  endfunction

  // Append to the feed and track what the block will hold once it is taken
  function automatic void plan_push(input span_txn_t t);
    logic [TEX_BITS-1:0] tex_addr;
    tex_addr = TEX_BITS'(t.address);
    column_feed.push_back(t);
    case (t.op)
      OP_TEX_WR: begin
        plan_tex[tex_addr]     = t.data;
        plan_tex_set[tex_addr] = 1'b1;
      end
      OP_SHADE_WR: begin
        plan_shade[t.address[BYTE_W-1:0]]     = t.data;
        plan_shade_set[t.address[BYTE_W-1:0]] = 1'b1;
      end
      OP_BLEND_WR: plan_blend_set[t.address] = 1'b1;
      OP_BEGIN: begin
        plan_pos  = t.start_position;
        plan_step = t.step;
      end
      OP_DRAW: plan_pos = plan_pos + plan_step;
      default: ;
    endcase
    if (t.op <= OP_DRAW) feed_count++;
  endfunction

  function automatic void queue_load(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                     input logic [BYTE_W-1:0] value);
    span_txn_t t;
    t         = random_txn(op);
    t.address = addr;
    t.data    = value;
    plan_push(t);
  endfunction

  function automatic void begin_column(input logic [POS_W-1:0] start, input logic [POS_W-1:0] step);
    span_txn_t t;
    t                = random_txn(OP_BEGIN);
    t.start_position = start;
    t.step           = step;
    plan_push(t);
  endfunction

  function automatic logic [BYTE_W-1:0] random_texel();
    return ($urandom_range(0, 4) == 0) ? SKIP_TEXEL : BYTE_W'($urandom);
  endfunction

  // Queue a draw, first loading every entry it will read that is still unwritten
  function automatic void queue_draw(input logic [BYTE_W-1:0] dest, input logic eoc);
    span_txn_t           t;
    logic [TEX_BITS-1:0] tex_addr;
    logic [BYTE_W-1:0]   texel;
    logic [BYTE_W-1:0]   shaded;
    logic [15:0]         blend_idx;
    tex_addr = TEX_BITS'(plan_pos >> texel_shift_q);
    if (!plan_tex_set[tex_addr]) queue_load(OP_TEX_WR, ADDR_W'(tex_addr), random_texel());
    texel = plan_tex[tex_addr];
    if (!plan_shade_set[texel])
      queue_load(OP_SHADE_WR, {BYTE_W'($urandom), texel}, BYTE_W'($urandom));
    shaded = plan_shade[texel];
    if (draw_mode_q != MODE_OPAQUE && draw_mode_q != MODE_MASKED && texel != SKIP_TEXEL) begin
      blend_idx = reverse_q ? {shaded, dest} : {dest, shaded};
      if (!plan_blend_set[blend_idx]) queue_load(OP_BLEND_WR, blend_idx, BYTE_W'($urandom));
    end
    t               = random_txn(OP_DRAW);
    t.dest_pixel    = dest;
    t.end_of_column = eoc;
    plan_push(t);
  endfunction

  // One column: mostly steps that revisit a small texel window, sometimes wild ones
  function automatic void queue_random_column();
    int unsigned      len;
    logic [POS_W-1:0] low_mask;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] step;
    low_mask = (32'd1 << texel_shift_q) - 32'd1;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    if ($urandom_range(0, 1) == 0)
      start = (32'($urandom_range(0, 63)) << texel_shift_q) | ($urandom & low_mask);
    else
      start = $urandom;
    case ($urandom_range(0, 5))
      0:       step = '0;
      1:       step = $urandom;
      2:       step = '1;
      default: step = (32'($urandom_range(0, 2)) << texel_shift_q) | ($urandom & low_mask);
    endcase
    // Occasionally carry on from where the last column stopped
    if ($urandom_range(0, 9) != 0) begin_column(start, step);
    for (int k = 0; k < len; k++)
      queue_draw(BYTE_W'($urandom), (k == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0));
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TEXEL_SHIFT: texel_shift_q = value[SHIFT_W-1:0];
      CFG_DRAW_MODE:   draw_mode_q   = value[MODE_W-1:0];
      CFG_REVERSE:     reverse_q     = value[0];
      default: ;
    endcase
  endtask

  // Wait for every transaction and pixel, then let trailing loads drain
  task automatic wait_until_quiet();
    @(negedge clk);
    while (column_feed.size() != 0 || column_in.valid || predicted_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(input logic [SHIFT_W-1:0] shift,
                                  input logic [MODE_W-1:0] mode,
                                  input logic rev, input logic idling);
    int unsigned target;
    wait_until_quiet();
    write_register(CFG_TEXEL_SHIFT, CFG_DATA_W'(shift));
    write_register(CFG_DRAW_MODE, CFG_DATA_W'(mode));
    write_register(CFG_REVERSE, CFG_DATA_W'(rev));
    idle_on <= idling;
    target = feed_count + PHASE_ITEMS;
    while (feed_count < target) begin
      case ($urandom_range(0, 19))
        0:       plan_push(random_txn(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
        1:       plan_push(random_txn(OP_W'($urandom_range(OP_TEX_WR, OP_BLEND_WR))));
        2:       plan_push(random_txn(OP_BEGIN));
        default: queue_random_column();
      endcase
    end
  endtask

  // Sender: present queued transactions, with random idle bursts
  span_txn_t   on_wire;
  int unsigned send_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      column_in.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (column_in.valid && column_in.ready) map_transaction(on_wire);
      if (!column_in.valid || column_in.ready) begin
        if (send_gap != 0) begin
          column_in.valid <= 1'b0;
          send_gap--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          column_in.valid <= 1'b0;
          send_gap = $urandom_range(0, 11);
        end else if (column_feed.size() != 0) begin
          on_wire = column_feed.pop_front();
          column_in.valid          <= 1'b1;
          column_in.op             <= on_wire.op;
          column_in.address        <= on_wire.address;
          column_in.data           <= on_wire.data;
          column_in.start_position <= on_wire.start_position;
          column_in.step           <= on_wire.step;
          column_in.dest_pixel     <= on_wire.dest_pixel;
          column_in.end_of_column  <= on_wire.end_of_column;
        end else begin
          column_in.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each pixel, stall in bursts and once for a long stretch
  int unsigned hold_left;
  bit          long_hold_done;

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      pixel_out.ready <= 1'b0;
      hold_left      = 0;
      long_hold_done = 1'b0;
    end else begin
      if (pixel_out.valid && pixel_out.ready) begin
        if (predicted_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %02h with nothing expected", pixel_out.new_pixel));
        end else begin
          want = predicted_pixels.pop_front();
          if (pixel_out.new_pixel !== want.new_pixel)
            report_mismatch($sformatf("new_pixel %02h, expected %02h",
                                      pixel_out.new_pixel, want.new_pixel));
          if (pixel_out.write_enable !== want.write_enable)
            report_mismatch($sformatf("write_enable %b, expected %b",
                                      pixel_out.write_enable, want.write_enable));
          if (pixel_out.column_done !== want.column_done)
            report_mismatch($sformatf("column_done %b, expected %b",
                                      pixel_out.column_done, want.column_done));
        end
        pixels_checked++;
      end
      if (hold_left != 0) begin
        pixel_out.ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && pixels_checked >= LONG_HOLD_AFTER) begin
        pixel_out.ready <= 1'b0;
        hold_left      = LONG_HOLD_CYCLES - 1;
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        pixel_out.ready <= 1'b0;
        hold_left = $urandom_range(0, 11);
      end else begin
        pixel_out.ready <= 1'b1;
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n                    = 1'b0;
    cfg_we                   = 1'b0;
    cfg_index                = CFG_TEXEL_SHIFT;
    cfg_wdata                = '0;
    idle_on                  = 1'b1;
    column_in.valid          = 1'b0;
    column_in.op             = OP_TEX_WR;
    column_in.address        = '0;
    column_in.data           = '0;
    column_in.start_position = '0;
    column_in.step           = '0;
    column_in.dest_pixel     = '0;
    column_in.end_of_column  = 1'b0;
    pixel_out.ready          = 1'b0;
    texel_shift_q            = TEXEL_SHIFT_RST;
    draw_mode_q              = MODE_OPAQUE;
    reverse_q                = 1'b0;
    tex_pos                  = '0;
    tex_step                 = '0;
    plan_pos                 = '0;
    plan_step                = '0;
    feed_count               = 0;
    mismatch_count           = 0;
    pixels_checked           = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Opaque at reset settings: address and data extremes, spare codes,
    // draw from the reset position, shade address upper bits dropped
    queue_load(OP_TEX_WR, 16'h0000, 8'h5A);
    queue_load(OP_TEX_WR, 16'hFFFF, SKIP_TEXEL);
    queue_load(OP_SHADE_WR, 16'h005A, 8'hA5);
    queue_load(OP_SHADE_WR, 16'hFFFF, 8'h00);
    queue_load(OP_BLEND_WR, 16'hFFFF, 8'h3C);
    queue_load(OP_BLEND_WR, 16'h0000, 8'hC3);
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) plan_push(random_txn(OP_W'(k)));
    queue_draw(8'h00, 1'b0);
    begin_column(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_draw(8'hFF, 1'b0);
    queue_draw(8'h00, 1'b1);

    // Masked at the top shift: skip texel passes the destination through
    wait_until_quiet();
    write_register(CFG_DRAW_MODE, CFG_DATA_W'(MODE_MASKED));
    write_register(CFG_TEXEL_SHIFT, CFG_DATA_W'(31));
    queue_load(OP_TEX_WR, 16'h0001, SKIP_TEXEL);
    begin_column(32'h0000_0000, 32'h0000_0000);
    queue_draw(8'h3E, 1'b1);
    begin_column(32'h8000_0000, 32'h8000_0000);
    queue_draw(8'hA7, 1'b0);
    queue_draw(8'hFF, 1'b1);

    // Translucent at zero shift: skip, then a blended pixel
    wait_until_quiet();
    write_register(CFG_DRAW_MODE, CFG_DATA_W'(MODE_BLEND));
    write_register(CFG_TEXEL_SHIFT, CFG_DATA_W'(0));
    begin_column(32'h0000_FFFF, 32'h0001_0001);
    queue_draw(8'hFF, 1'b0);
    queue_draw(8'h00, 1'b1);

    // Random columns across settings; the last stretch runs without idling
    run_random_phase(SHIFT_W'(31), MODE_BLEND_ALT, 1'b1, 1'b1);
    run_random_phase(SHIFT_W'(0), MODE_BLEND, 1'b1, 1'b1);
    run_random_phase(SHIFT_W'($urandom), MODE_MASKED, 1'b0, 1'b1);
    run_random_phase(SHIFT_W'($urandom_range(8, 20)), MODE_BLEND, 1'b0, 1'b0);
    run_random_phase(TEXEL_SHIFT_RST, MODE_OPAQUE, 1'b1, 1'b1);
    run_random_phase(SHIFT_W'($urandom), MODE_BLEND_ALT, 1'($urandom), 1'b0);

    wait_until_quiet();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
